### hdl/tccs_pkg.sv
`timescale 1ns / 1ps

package tccs_pkg;

	localparam int OPCODE_W   = 2;
	localparam int CHAR_W     = 8;
	localparam int INDEX_W    = 11;
	localparam int COLOR_W    = 8;
	localparam int CELL_W     = 16;
	localparam int ROW_OUT_W  = 5;
	localparam int COL_OUT_W  = 7;

	localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
	localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h0A;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_FILL
	} tccs_state_t;

endpackage

### hdl/tccs_if.sv
`timescale 1ns / 1ps

interface tccs_req_if;
	logic                           valid;
	logic                           ready;
	logic [tccs_pkg::OPCODE_W-1:0]  opcode;
	logic [tccs_pkg::CHAR_W-1:0]    char_code;
	logic [tccs_pkg::INDEX_W-1:0]   cell_index;

	modport source(output valid, opcode, char_code, cell_index, input ready);
	modport sink(input valid, opcode, char_code, cell_index, output ready);
endinterface

interface tccs_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [tccs_pkg::CELL_W-1:0]    cell_data;
	logic [tccs_pkg::ROW_OUT_W-1:0] cursor_row;
	logic [tccs_pkg::COL_OUT_W-1:0] cursor_column;
	logic                           scrolled;

	modport source(output valid, cell_data, cursor_row, cursor_column, scrolled, input ready);
	modport sink(input valid, cell_data, cursor_row, cursor_column, scrolled, output ready);
endinterface

interface tccs_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tccs_pkg::COLOR_W-1:0]   text_color;

	modport source(output valid, text_color, input ready);
	modport sink(input valid, text_color, output ready);
endinterface

### hdl/text_console_cursor_scroll.sv
`timescale 1ns / 1ps

// Text console engine: a screen of ROWS x COLUMNS cells (character in the low byte,
// attribute in the high byte) in one synchronous RAM, plus a cursor. Rows are kept
// circularly in the RAM, so a scroll only moves the top-row base and blanks one row.
// A put, an unused opcode and a scroll-free request are answered straight from the
// response register; a read also passes the RAM read register and the read state. A
// put that scrolls returns its response at once, then the write port blanks the new
// bottom row; a clear blanks every cell. After reset the same clearing pass runs
// before the first request is taken; text_color writes are taken at any time.
// The blanking color is latched when the pass starts.
module text_console_cursor_scroll #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	tccs_req_if.sink    req,
	tccs_rsp_if.source  rsp,
	tccs_cfg_if.sink    cfg
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int AW         = $clog2(CELL_COUNT);
	localparam int SW         = ((AW > tccs_pkg::INDEX_W) ? AW : tccs_pkg::INDEX_W) + 1;
	localparam int RW         = $clog2(ROWS);
	localparam int CW         = $clog2(COLUMNS);

	localparam logic [AW:0]   CELLS_A  = (AW+1)'(CELL_COUNT);
	localparam logic [SW-1:0] CELLS_S  = SW'(CELL_COUNT);
	localparam logic [AW-1:0] LAST_CELL  = AW'(CELL_COUNT - 1);
	localparam logic [AW-1:0] BOTTOM_LIN = AW'(CELL_COUNT - COLUMNS);
	localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
	localparam logic [AW-1:0] COLS_M1_A  = AW'(COLUMNS - 1);
	localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
	localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);

	tccs_pkg::tccs_state_t state_q, state_d;

	logic [RW-1:0]                  row_q;
	logic [CW-1:0]                  col_q;
	logic [AW-1:0]                  lin_q;
	logic [AW-1:0]                  base_q;
	logic [tccs_pkg::COLOR_W-1:0]   color_q;
	logic [AW-1:0]                  fill_addr_q;
	logic [AW-1:0]                  fill_end_q;
	logic [tccs_pkg::COLOR_W-1:0]   fill_attr_q;
	logic                           rd_ok_q;

	logic                           out_valid_q;
	logic [tccs_pkg::CELL_W-1:0]    out_data_q;
	logic [tccs_pkg::ROW_OUT_W-1:0] out_row_q;
	logic [tccs_pkg::COL_OUT_W-1:0] out_col_q;
	logic                           out_scr_q;

	logic                           req_ready;
	logic                           acc;
	logic                           we;
	logic                           re;
	logic [AW-1:0]                  waddr;
	logic [tccs_pkg::CELL_W-1:0]    wdata;
	logic [tccs_pkg::CELL_W-1:0]    rdata;

	logic [AW:0]                    put_sum;
	logic [AW-1:0]                  put_addr;
	logic [SW-1:0]                  idx_ext;
	logic [SW-1:0]                  rd_sum;
	logic [AW-1:0]                  rd_addr;
	logic                           rd_in;

	logic                           is_nl;
	logic                           adv;
	logic                           at_last;
	logic                           do_scroll;
	logic [CW-1:0]                  nxt_col;
	logic [RW-1:0]                  nxt_row;
	logic [AW-1:0]                  nxt_lin;
	logic [AW-1:0]                  base_nxt;

	// physical address of the cursor cell and of the read request
	assign put_sum  = {1'b0, lin_q} + {1'b0, base_q};
	assign put_addr = (put_sum >= CELLS_A) ? AW'(put_sum - CELLS_A) : AW'(put_sum);

	assign idx_ext  = SW'(req.cell_index);
	assign rd_in    = idx_ext < CELLS_S;
	assign rd_sum   = idx_ext + SW'(base_q);
	assign rd_addr  = (rd_sum >= CELLS_S) ? AW'(rd_sum - CELLS_S) : AW'(rd_sum);

	// cursor advance for a put
	assign is_nl     = req.char_code == tccs_pkg::NEWLINE_CODE;
	assign adv       = is_nl || (col_q == LAST_COL);
	assign at_last   = row_q == LAST_ROW;
	assign do_scroll = adv && at_last;
	assign nxt_col   = adv ? '0 : col_q + CW'(1);
	assign nxt_row   = (adv && !at_last) ? row_q + RW'(1) : row_q;
	assign nxt_lin   = !adv ? lin_q + AW'(1) :
	                   at_last ? BOTTOM_LIN : lin_q - AW'(col_q) + COLS_A;
	assign base_nxt  = (base_q == BOTTOM_LIN) ? '0 : base_q + COLS_A;

	assign acc = req.valid && req_ready;

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		we        = 1'b0;
		re        = 1'b0;
		waddr     = put_addr;
		wdata     = {color_q, req.char_code};
		unique case (state_q)
			tccs_pkg::ST_IDLE: begin
				req_ready = !out_valid_q || rsp.ready;
				if (req.valid && req_ready) begin
					unique case (req.opcode)
						tccs_pkg::OP_PUT: begin
							we = !is_nl;
							if (do_scroll) begin
								state_d = tccs_pkg::ST_FILL;
							end
						end
						tccs_pkg::OP_READ: begin
							re      = 1'b1;
							state_d = tccs_pkg::ST_READ;
						end
						tccs_pkg::OP_CLEAR: begin
							state_d = tccs_pkg::ST_FILL;
						end
						default: ;
					endcase
				end
			end
			tccs_pkg::ST_READ: begin
				state_d = tccs_pkg::ST_IDLE;
			end
			tccs_pkg::ST_FILL: begin
				we    = 1'b1;
				waddr = fill_addr_q;
				wdata = {fill_attr_q, tccs_pkg::SPACE_CODE};
				if (fill_addr_q == fill_end_q) begin
					state_d = tccs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tccs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tccs_pkg::ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	tccs_ram #(
		.WIDTH(tccs_pkg::CELL_W),
		.DEPTH(CELL_COUNT)
	) u_screen (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// cursor, row base, blanking pass and color
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			lin_q       <= '0;
			base_q      <= '0;
			color_q     <= tccs_pkg::RESET_COLOR;
			fill_addr_q <= '0;
			fill_end_q  <= LAST_CELL;
			fill_attr_q <= tccs_pkg::RESET_COLOR;
			rd_ok_q     <= 1'b0;
		end else begin
			if (cfg.valid) begin
				color_q <= cfg.text_color;
			end
			if (state_q == tccs_pkg::ST_FILL) begin
				fill_addr_q <= fill_addr_q + AW'(1);
			end
			if (acc) begin
				unique case (req.opcode)
					tccs_pkg::OP_PUT: begin
						row_q <= nxt_row;
						col_q <= nxt_col;
						lin_q <= nxt_lin;
						if (do_scroll) begin
							// old top row becomes the new bottom row: blank it
							base_q      <= base_nxt;
							fill_addr_q <= base_q;
							fill_end_q  <= base_q + COLS_M1_A;
							fill_attr_q <= color_q;
						end
					end
					tccs_pkg::OP_READ: begin
						rd_ok_q <= rd_in;
					end
					tccs_pkg::OP_CLEAR: begin
						row_q       <= '0;
						col_q       <= '0;
						lin_q       <= '0;
						base_q      <= '0;
						fill_addr_q <= '0;
						fill_end_q  <= LAST_CELL;
						fill_attr_q <= color_q;
					end
					default: ;
				endcase
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((acc && req.opcode != tccs_pkg::OP_READ) ||
		             state_q == tccs_pkg::ST_READ) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tccs_pkg::ST_READ) begin
			out_data_q <= rd_ok_q ? rdata : '0;
			out_row_q  <= tccs_pkg::ROW_OUT_W'(row_q);
			out_col_q  <= tccs_pkg::COL_OUT_W'(col_q);
			out_scr_q  <= 1'b0;
		end else if (acc) begin
			out_data_q <= '0;
			out_scr_q  <= 1'b0;
			unique case (req.opcode)
				tccs_pkg::OP_PUT: begin
					out_row_q <= tccs_pkg::ROW_OUT_W'(nxt_row);
					out_col_q <= tccs_pkg::COL_OUT_W'(nxt_col);
					out_scr_q <= do_scroll;
				end
				tccs_pkg::OP_CLEAR: begin
					out_row_q <= '0;
					out_col_q <= '0;
				end
				default: begin
					out_row_q <= tccs_pkg::ROW_OUT_W'(row_q);
					out_col_q <= tccs_pkg::COL_OUT_W'(col_q);
				end
			endcase
		end
	end

	assign req.ready         = req_ready;
	assign cfg.ready         = 1'b1;
	assign rsp.valid         = out_valid_q;
	assign rsp.cell_data     = out_data_q;
	assign rsp.cursor_row    = out_row_q;
	assign rsp.cursor_column = out_col_q;
	assign rsp.scrolled      = out_scr_q;

	a_cursor_lin: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q < LAST_ROW || row_q == LAST_ROW) && (col_q < LAST_COL || col_q == LAST_COL) &&
		(32'(lin_q) == 32'(row_q) * COLUMNS + 32'(col_q)))
		else $error("cursor row/column out of step with linear position");

	a_no_req_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tccs_pkg::ST_FILL |-> !req.ready)
		else $error("request taken during blanking pass");

	a_read_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tccs_pkg::ST_READ |=> rsp.valid)
		else $error("read did not produce a response");

	a_scroll_fill: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.opcode == tccs_pkg::OP_PUT && do_scroll |=>
		state_q == tccs_pkg::ST_FILL && rsp.valid && rsp.scrolled)
		else $error("scroll did not start bottom row blanking");

endmodule

### hdl/tccs_ram.sv
`timescale 1ns / 1ps

module tccs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### test/tccs_screen_checker.sv
`timescale 1ns / 1ps

module tccs_screen_checker (
	input  logic clk,
	input  logic arst_n,
	tccs_req_if  req,
	tccs_rsp_if  rsp,
	tccs_cfg_if  cfg,
	output int   error_count,
	output int   pending_count
);

	localparam int COLS      = 80;
	localparam int ROW_COUNT = 25;
	localparam int CELLS     = COLS * ROW_COUNT;

	typedef struct packed {
		logic [tccs_pkg::CELL_W-1:0]    cell_data;
		logic [tccs_pkg::ROW_OUT_W-1:0] cursor_row;
		logic [tccs_pkg::COL_OUT_W-1:0] cursor_column;
		logic                           scrolled;
	} console_rsp_t;

	logic [tccs_pkg::CELL_W-1:0]  screen_image [CELLS];
	int unsigned                  cur_row;
	int unsigned                  cur_col;
	logic [tccs_pkg::COLOR_W-1:0] pen_color;
	console_rsp_t                 predicted_q [$];
	console_rsp_t                 want;
	console_rsp_t                 got;
	int                           mismatch_total = 0;

	function automatic void blank_screen(logic [tccs_pkg::COLOR_W-1:0] color);
		for (int i = 0; i < CELLS; i++)
			screen_image[i] = {color, tccs_pkg::SPACE_CODE};
	endfunction

	// Update the screen image and cursor for one request and return its response.
	function automatic console_rsp_t next_console_rsp(logic [tccs_pkg::OPCODE_W-1:0] op,
			logic [tccs_pkg::CHAR_W-1:0] ch, logic [tccs_pkg::INDEX_W-1:0] idx);
		console_rsp_t r;
		logic         advance;
		int unsigned  pos;
		r = '0;
		advance = 1'b0;
		unique case (op)
			tccs_pkg::OP_PUT: begin
				if (ch == tccs_pkg::NEWLINE_CODE) begin
					advance = 1'b1;
				end else begin
					pos = cur_row * COLS + cur_col;
					if (pos < CELLS)
						screen_image[pos] = {pen_color, ch};
					cur_col++;
					if (cur_col >= COLS)
						advance = 1'b1;
				end
				if (advance) begin
					cur_col = 0;
					cur_row++;
					if (cur_row >= ROW_COUNT) begin
						for (int i = 0; i < CELLS - COLS; i++)
							screen_image[i] = screen_image[i + COLS];
						for (int x = 0; x < COLS; x++)
							screen_image[CELLS - COLS + x] = {pen_color, tccs_pkg::SPACE_CODE};
						cur_row = ROW_COUNT - 1;
						r.scrolled = 1'b1;
					end
				end
			end
			tccs_pkg::OP_READ: begin
				if (idx < CELLS)
					r.cell_data = screen_image[idx];
			end
			tccs_pkg::OP_CLEAR: begin
				blank_screen(pen_color);
				cur_row = 0;
				cur_col = 0;
			end
			default: ;
		endcase
		r.cursor_row    = cur_row[tccs_pkg::ROW_OUT_W-1:0];
		r.cursor_column = cur_col[tccs_pkg::COL_OUT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_color = tccs_pkg::RESET_COLOR;
			blank_screen(tccs_pkg::RESET_COLOR);
			cur_row = 0;
			cur_col = 0;
			predicted_q.delete();
		end else begin
			// Match the response first: a request taken at this edge cannot answer it.
			if (rsp.valid && rsp.ready) begin
				got = {rsp.cell_data, rsp.cursor_row, rsp.cursor_column, rsp.scrolled};
				if (predicted_q.size() == 0) begin
					$error("response with no request pending: %h", got);
					mismatch_total++;
				end else begin
					want = predicted_q.pop_front();
					if (got.cell_data !== want.cell_data) begin
						$error("cell_data expected %h got %h", want.cell_data, got.cell_data);
						mismatch_total++;
					end
					if (got.cursor_row !== want.cursor_row) begin
						$error("cursor_row expected %0d got %0d", want.cursor_row,
							got.cursor_row);
						mismatch_total++;
					end
					if (got.cursor_column !== want.cursor_column) begin
						$error("cursor_column expected %0d got %0d", want.cursor_column,
							got.cursor_column);
						mismatch_total++;
					end
					if (got.scrolled !== want.scrolled) begin
						$error("scrolled expected %b got %b", want.scrolled, got.scrolled);
						mismatch_total++;
					end
				end
			end
			if (cfg.valid && cfg.ready)
				pen_color = cfg.text_color;
			if (req.valid && req.ready)
				predicted_q.push_back(next_console_rsp(req.opcode, req.char_code,
					req.cell_index));
		end
		error_count   <= mismatch_total;
		pending_count <= predicted_q.size();
	end

endmodule

### test/tb_text_console_cursor_scroll.sv
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll;

	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int ITEMS_PER_PHASE = 350;
	localparam int SETTLE_CYCLES   = 2100;
	localparam int HOLD_CYCLES     = 400;
	localparam int ROW_COUNT       = 25;
	localparam logic [tccs_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	int   send_idle_pct = 0;
	int   stall_pct = 0;
	logic hold_off_go = 1'b0;
	int   error_count;
	int   pending_count;
	int   cycle_count = 0;

	tccs_req_if req_ch ();
	tccs_rsp_if rsp_ch ();
	tccs_cfg_if cfg_ch ();

	text_console_cursor_scroll u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	tccs_screen_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.cfg           (cfg_ch),
		.error_count   (error_count),
		.pending_count (pending_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_text_console_cursor_scroll failed");
			$finish;
		end
	end

	// Response ready: random stalls, plus one long hold-off to back up the block.
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_off_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_req(input logic [tccs_pkg::OPCODE_W-1:0] op,
			input logic [tccs_pkg::CHAR_W-1:0] ch, input logic [tccs_pkg::INDEX_W-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.opcode     <= op;
		req_ch.char_code  <= ch;
		req_ch.cell_index <= idx;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
	endtask

	// Drop valid, wait for every response, then let any blanking pass finish.
	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_color(input logic [tccs_pkg::COLOR_W-1:0] color);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.text_color <= color;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_phase(input int idle, input int stall,
			input logic [tccs_pkg::COLOR_W-1:0] color, input bit pressure);
		int                           sent;
		int                           kind;
		int                           len;
		int                           pick;
		logic [tccs_pkg::CHAR_W-1:0]  ch;
		logic [tccs_pkg::INDEX_W-1:0] idx;
		sent = 0;
		settle();
		write_color(color);
		send_idle_pct = idle;
		stall_pct <= stall;
		if (pressure)
			hold_off_go <= 1'b1;
		while (sent < ITEMS_PER_PHASE) begin
			kind = $urandom_range(99);
			if (kind < 40) begin
				// text run, long enough at times to wrap a line
				len = $urandom_range(100, 1);
				for (int k = 0; k < len; k++) begin
					ch = ($urandom_range(11) == 0) ? tccs_pkg::NEWLINE_CODE :
						tccs_pkg::CHAR_W'($urandom_range(255));
					send_req(tccs_pkg::OP_PUT, ch, tccs_pkg::INDEX_W'($urandom_range(2047)));
					sent++;
				end
			end else if (kind < 55) begin
				len = $urandom_range(30, 1);
				for (int k = 0; k < len; k++) begin
					send_req(tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE,
						tccs_pkg::INDEX_W'($urandom_range(2047)));
					sent++;
				end
			end else if (kind < 80) begin
				len = $urandom_range(8, 1);
				for (int k = 0; k < len; k++) begin
					pick = $urandom_range(9);
					if (pick < 5)
						idx = tccs_pkg::INDEX_W'($urandom_range(1999, 1760));
					else if (pick < 9)
						idx = tccs_pkg::INDEX_W'($urandom_range(1999));
					else
						idx = tccs_pkg::INDEX_W'($urandom_range(2047, 2000));
					send_req(tccs_pkg::OP_READ, tccs_pkg::CHAR_W'($urandom_range(255)), idx);
					sent++;
				end
			end else if (kind < 83) begin
				send_req(tccs_pkg::OP_CLEAR, tccs_pkg::CHAR_W'($urandom_range(255)),
					tccs_pkg::INDEX_W'($urandom_range(2047)));
				sent++;
			end else if (kind < 86) begin
				send_req(OP_UNUSED, tccs_pkg::CHAR_W'($urandom_range(255)),
					tccs_pkg::INDEX_W'($urandom_range(2047)));
				sent++;
			end else begin
				send_req(tccs_pkg::OP_PUT, tccs_pkg::CHAR_W'($urandom_range(255)),
					tccs_pkg::INDEX_W'($urandom_range(2047)));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.opcode     = tccs_pkg::OP_PUT;
		req_ch.char_code  = '0;
		req_ch.cell_index = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.text_color = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset contents, read range limits, put extremes, unused opcode
		send_req(tccs_pkg::OP_READ, 8'h00, 11'd0);
		send_req(tccs_pkg::OP_READ, 8'hFF, 11'd1999);
		send_req(tccs_pkg::OP_READ, 8'h00, 11'd2000);
		send_req(tccs_pkg::OP_READ, 8'h00, 11'h7FF);
		send_req(tccs_pkg::OP_PUT, 8'h00, 11'd0);
		send_req(tccs_pkg::OP_PUT, 8'hFF, 11'h7FF);
		send_req(tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE, 11'd0);
		send_req(tccs_pkg::OP_PUT, 8'h41, 11'd0);
		send_req(OP_UNUSED, 8'hFF, 11'h7FF);
		send_req(tccs_pkg::OP_READ, 8'h00, 11'd0);
		send_req(tccs_pkg::OP_READ, 8'h00, 11'd1);
		send_req(tccs_pkg::OP_READ, 8'h00, 11'd80);
		send_req(tccs_pkg::OP_CLEAR, 8'h00, 11'd0);
		send_req(tccs_pkg::OP_READ, 8'h00, 11'd0);
		// walk down to the last row; the final newline scrolls
		for (int k = 0; k < ROW_COUNT; k++)
			send_req(tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE, 11'd0);
		send_req(tccs_pkg::OP_PUT, 8'h5A, 11'd0);
		send_req(tccs_pkg::OP_READ, 8'h00, 11'd1920);
		send_req(tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE, 11'd0);
		send_req(tccs_pkg::OP_READ, 8'h00, 11'd1840);
		send_req(tccs_pkg::OP_READ, 8'h00, 11'd1920);

		run_phase(0, 0, 8'h00, 1'b1);
		run_phase(76, 0, 8'hFF, 1'b0);
		run_phase(0, 76, tccs_pkg::COLOR_W'($urandom_range(255)), 1'b0);
		run_phase(11, 11, tccs_pkg::COLOR_W'($urandom_range(255)), 1'b0);
		settle();

		if (error_count == 0 && pending_count == 0)
			$display("tb_text_console_cursor_scroll passed");
		else
			$display("tb_text_console_cursor_scroll failed");
		$finish;
	end

endmodule
